### rtl/assert_macros.svh
// shared assertion macros, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/wcm_pkg.sv
package wcm_pkg;

  localparam int unsigned SCREEN_HEIGHT = 512;
  localparam int unsigned TILE_SIZE     = 64;

  localparam int unsigned TEX_H_W   = 13;
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned QUO_W     = 13;
  localparam int unsigned REM_W     = 30;
  localparam int unsigned DSH_W     = 29;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [11:0] TEX_ROW_MAX = 12'hFFF;
  localparam logic [TEX_H_W-1:0] TEX_H_RESET = 13'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_3 = 3'd3;

  // fields that ride along with an item
  typedef struct packed {
    logic [9:0] column;
    logic [8:0] row;
    logic       in_wall;
    logic [1:0] texture;
    logic [5:0] tex_col;
  } wcm_side_t;

  // one item inside the divider pipe
  typedef struct packed {
    wcm_side_t          side;
    logic [REM_W-1:0]   rem;
    logic [DSH_W-1:0]   dsh;
    logic [QUO_W-1:0]   quo;
  } wcm_div_t;

endpackage

### rtl/wcm_div_step.sv
`include "assert_macros.svh"

module wcm_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  wcm_pkg::wcm_div_t data_i,
  output logic              stall_o,
  output logic              valid_o,
  output wcm_pkg::wcm_div_t data_o,
  input  logic              stall_i
);

  logic              valid_q;
  wcm_pkg::wcm_div_t data_q, data_d;
  logic              ready;
  logic              ge;

  assign ready   = !valid_q || !stall_i;
  assign stall_o = !ready;

  // one restoring step: compare, subtract, shift in a quotient bit
  always_comb begin
    ge          = {1'b0, data_i.dsh} <= data_i.rem;
    data_d      = data_i;
    data_d.rem  = ge ? (data_i.rem - {1'b0, data_i.dsh}) : data_i.rem;
    data_d.quo  = {data_i.quo[wcm_pkg::QUO_W-2:0], ge};
    data_d.dsh  = data_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `ASSERT_PROP(a_hold_on_stall, valid_q && stall_i |=> valid_q && $stable(data_q), "item changed while stalled")
  `ASSERT_PROP(a_rem_bound, valid_q |-> (data_q.rem < {data_q.dsh, 1'b0}) || (data_q.rem == '0), "remainder out of bound")
  `ASSERT_PROP(a_dsh_shift, valid_i && !stall_o |=> data_q.dsh == ($past(data_i.dsh) >> 1), "divisor not shifted")

endmodule

### rtl/wall_column_texture_mapper_unit.sv
// throughput: one item per cycle while the output is not stalled; every stage holds one item and the 13-step
//   restoring divider is unrolled one quotient bit per stage
// stalls back up stage by stage, so bubbles are squeezed out while the output waits
// reset: asynchronous active low, empties the pipe and sets all texture heights to 64
`include "assert_macros.svh"

module wall_column_texture_mapper_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [wcm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wcm_pkg::TEX_H_W-1:0]        cfg_data_i,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [9:0]                         column_i,
  input  logic [8:0]                         row_i,
  input  logic [15:0]                        wall_height_i,
  input  logic [1:0]                         texture_index_i,
  input  logic                               hit_vertical_i,
  input  logic [15:0]                        hit_x_i,
  input  logic [15:0]                        hit_y_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [9:0]                         out_column_o,
  output logic [8:0]                         out_row_o,
  output logic                               in_wall_o,
  output logic [1:0]                         out_texture_o,
  output logic [5:0]                         tex_col_o,
  output logic [11:0]                        tex_row_o
);

  localparam logic [15:0] TILE_MASK = 16'(wcm_pkg::TILE_SIZE - 1);
  localparam logic [17:0] SCR_H     = 18'(wcm_pkg::SCREEN_HEIGHT);

  // texture height registers
  logic [3:0][wcm_pkg::TEX_H_W-1:0] tex_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_height_q <= {4{wcm_pkg::TEX_H_RESET}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wcm_pkg::REG_TEX_HEIGHT_0: tex_height_q[0] <= cfg_data_i;
        wcm_pkg::REG_TEX_HEIGHT_1: tex_height_q[1] <= cfg_data_i;
        wcm_pkg::REG_TEX_HEIGHT_2: tex_height_q[2] <= cfg_data_i;
        wcm_pkg::REG_TEX_HEIGHT_3: tex_height_q[3] <= cfg_data_i;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // handshake chain, each stage moves when it is empty or its successor moves
  logic ready_a, ready_b, ready_c, ready_out;
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic [wcm_pkg::DIV_STEPS:0] div_valid;
  logic [wcm_pkg::DIV_STEPS:0] div_stall;
  wcm_pkg::wcm_div_t           div_data [wcm_pkg::DIV_STEPS+1];

  assign ready_out = !out_valid_q || !out_stall_i;
  assign ready_c   = !c_valid_q || !div_stall[0];
  assign ready_b   = !b_valid_q || ready_c;
  assign ready_a   = !a_valid_q || ready_b;
  assign in_stall_o = !ready_a;

  // stage a: capture the item, pick the texture column
  wcm_pkg::wcm_side_t a_side_q;
  logic [15:0]        a_h_q;
  logic [15:0]        hit_sel;

  assign hit_sel = hit_vertical_i ? hit_y_i : hit_x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_a) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      a_side_q.column  <= column_i;
      a_side_q.row     <= row_i;
      a_side_q.in_wall <= 1'b0;
      a_side_q.texture <= texture_index_i;
      a_side_q.tex_col <= 6'(hit_sel & TILE_MASK);
      a_h_q            <= wall_height_i;
    end
  end

  // stage b: wall span, numerator and texture height
  logic [17:0] h_ext, row_ext, span_start, span_end, num_sum;
  logic        h_small, wall_b, num_pos;
  logic [wcm_pkg::NUM_W-1:0] num_b;
  wcm_pkg::wcm_side_t        b_side_d;

  wcm_pkg::wcm_side_t         b_side_q;
  logic [wcm_pkg::NUM_W-1:0]  b_num_q;
  logic [wcm_pkg::TEX_H_W-1:0] b_th_q;
  logic [15:0]                b_h_q;

  always_comb begin
    h_ext      = 18'(a_h_q);
    row_ext    = 18'(a_side_q.row);
    h_small    = h_ext < SCR_H;
    span_start = h_small ? ((SCR_H - h_ext) >> 1) : 18'd0;
    span_end   = h_small ? ((SCR_H + h_ext) >> 1) : SCR_H;
    // zero height is never wall
    wall_b     = (a_h_q != 16'd0) && (row_ext >= span_start) && (row_ext < span_end);
    num_sum    = {row_ext[16:0], 1'b0} + h_ext;
    // top edge row can give -1, which clamps to 0
    num_pos    = num_sum > SCR_H;
    num_b      = (wall_b && num_pos) ? wcm_pkg::NUM_W'(num_sum - SCR_H) : '0;
    b_side_d         = a_side_q;
    b_side_d.in_wall = wall_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (ready_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && a_valid_q) begin
      b_side_q <= b_side_d;
      b_num_q  <= num_b;
      b_th_q   <= tex_height_q[a_side_q.texture];
      b_h_q    <= a_h_q;
    end
  end

  // stage c: dividend num * th, divisor 2h aligned to the top quotient bit
  wcm_pkg::wcm_div_t c_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (ready_c) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && b_valid_q) begin
      c_data_q.side <= b_side_q;
      c_data_q.rem  <= wcm_pkg::REM_W'(b_num_q) * wcm_pkg::REM_W'(b_th_q);
      c_data_q.dsh  <= wcm_pkg::DSH_W'(b_h_q) << wcm_pkg::QUO_W;
      c_data_q.quo  <= '0;
    end
  end

  // divider: one quotient bit per stage, quotient below th whenever th is nonzero
  assign div_valid[0] = c_valid_q;
  assign div_data[0]  = c_data_q;
  assign div_stall[wcm_pkg::DIV_STEPS] = !ready_out;

  for (genvar k = 0; k < wcm_pkg::DIV_STEPS; k++) begin : g_div
    wcm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .data_i  (div_data[k]),
      .stall_o (div_stall[k]),
      .valid_o (div_valid[k+1]),
      .data_o  (div_data[k+1]),
      .stall_i (div_stall[k+1])
    );
  end

  // output register: saturate and clear tex_row outside the wall
  wcm_pkg::wcm_div_t  fin;
  wcm_pkg::wcm_side_t out_side_q;
  logic [11:0]        out_tex_row_q;
  logic [11:0]        tex_row_d;

  assign fin = div_data[wcm_pkg::DIV_STEPS];

  always_comb begin
    if (!fin.side.in_wall) begin
      tex_row_d = 12'd0;
    end else if (fin.quo[wcm_pkg::QUO_W-1]) begin
      tex_row_d = wcm_pkg::TEX_ROW_MAX;
    end else begin
      tex_row_d = fin.quo[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= div_valid[wcm_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_out && div_valid[wcm_pkg::DIV_STEPS]) begin
      out_side_q    <= fin.side;
      out_tex_row_q <= tex_row_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_column_o  = out_side_q.column;
  assign out_row_o     = out_side_q.row;
  assign in_wall_o     = out_side_q.in_wall;
  assign out_texture_o = out_side_q.texture;
  assign tex_col_o     = out_side_q.tex_col;
  assign tex_row_o     = out_tex_row_q;

  `ASSERT_PROP(a_no_row_off_wall, out_valid_q && !out_side_q.in_wall |-> out_tex_row_q == 12'd0, "tex_row set outside wall")
  `ASSERT_PROP(a_bad_idx_ignored, cfg_we_i && cfg_idx_i[2] |=> $stable(tex_height_q), "write past register list took effect")
  `ASSERT_PROP(a_out_hold, out_valid_q && out_stall_i |=> out_valid_q && $stable(out_side_q) && $stable(out_tex_row_q), "result lost under stall")
  `ASSERT_NEVER(a_zero_h_wall, b_valid_q && b_side_q.in_wall && (b_h_q == 16'd0), "zero height marked as wall")

endmodule

### bench/wcm_pixel_checker.sv
`timescale 1ns / 1ps

module wcm_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [9:0]  column_i,
  input  logic [8:0]  row_i,
  input  logic [15:0] wall_height_i,
  input  logic [1:0]  texture_index_i,
  input  logic        hit_vertical_i,
  input  logic [15:0] hit_x_i,
  input  logic [15:0] hit_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [9:0]  out_column_i,
  input  logic [8:0]  out_row_i,
  input  logic        in_wall_i,
  input  logic [1:0]  out_texture_i,
  input  logic [5:0]  tex_col_i,
  input  logic [11:0] tex_row_i,
  output int          errors_o,
  output int          pending_o
);
  import wcm_pkg::*;

  typedef struct packed {
    logic [9:0]  column;
    logic [8:0]  row;
    logic        in_wall;
    logic [1:0]  texture;
    logic [5:0]  tex_col;
    logic [11:0] tex_row;
  } pixel_t;

  logic [TEX_H_W-1:0] tex_h [4];
  pixel_t             expected_pixels [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  // texture lookup for one screen pixel
  function automatic pixel_t shade_pixel(input logic [9:0] col, input logic [8:0] row,
                                         input logic [15:0] h, input logic [1:0] tex,
                                         input logic vert, input logic [15:0] hx,
                                         input logic [15:0] hy);
    pixel_t      p;
    logic [15:0] coord;
    int unsigned span_top;
    int unsigned span_end;
    longint      num;
    longint      quo;
    p.column  = col;
    p.row     = row;
    p.texture = tex;
    p.in_wall = 1'b0;
    p.tex_row = '0;
    coord     = vert ? hy : hx;
    p.tex_col = 6'(coord % TILE_SIZE);
    if (h != 0) begin
      if (h < SCREEN_HEIGHT) begin
        span_top = (SCREEN_HEIGHT - h) / 2;
        span_end = (SCREEN_HEIGHT + h) / 2;
      end else begin
        span_top = 0;
        span_end = SCREEN_HEIGHT;
      end
      if (row >= span_top && row < span_end) begin
        p.in_wall = 1'b1;
        num = 2 * longint'(row) + longint'(h) - longint'(SCREEN_HEIGHT);
        // top edge gives -1, clamped to row 0
        if (num > 0) begin
          quo = num * longint'(tex_h[tex]) / (2 * longint'(h));
          p.tex_row = (quo > longint'(TEX_ROW_MAX)) ? TEX_ROW_MAX : 12'(quo);
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) tex_h[k] = TEX_H_RESET;
      expected_pixels.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_TEX_HEIGHT_3) tex_h[cfg_idx_i[1:0]] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with no item outstanding");
          errors_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_column_i !== want.column) begin
            $error("out_column expected %0d got %0d", want.column, out_column_i);
            errors_o++;
          end
          if (out_row_i !== want.row) begin
            $error("out_row expected %0d got %0d", want.row, out_row_i);
            errors_o++;
          end
          if (in_wall_i !== want.in_wall) begin
            $error("in_wall expected %0d got %0d", want.in_wall, in_wall_i);
            errors_o++;
          end
          if (out_texture_i !== want.texture) begin
            $error("out_texture expected %0d got %0d", want.texture, out_texture_i);
            errors_o++;
          end
          if (tex_col_i !== want.tex_col) begin
            $error("tex_col expected %0d got %0d", want.tex_col, tex_col_i);
            errors_o++;
          end
          if (tex_row_i !== want.tex_row) begin
            $error("tex_row expected %0d got %0d", want.tex_row, tex_row_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(shade_pixel(column_i, row_i, wall_height_i, texture_index_i,
                                              hit_vertical_i, hit_x_i, hit_y_i));
      pending_o = expected_pixels.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wcm_pkg::*;

  // slowest run is about 1100 items plus drains, so this is generous
  localparam int LIMIT        = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 175;
  localparam int TAIL_CYCLES  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [9:0]  column;
  logic [8:0]  row;
  logic [15:0] wall_height;
  logic [1:0]  texture_index;
  logic        hit_vertical;
  logic [15:0] hit_x;
  logic [15:0] hit_y;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_column;
  logic [8:0]  out_row;
  logic        in_wall;
  logic [1:0]  out_texture;
  logic [5:0]  tex_col;
  logic [11:0] tex_row;

  int mismatches;
  int pending;
  int cycle_count;
  // when set, neither side idles, giving back-to-back stretches
  bit steady;

  wall_column_texture_mapper_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .column_i        (column),
    .row_i           (row),
    .wall_height_i   (wall_height),
    .texture_index_i (texture_index),
    .hit_vertical_i  (hit_vertical),
    .hit_x_i         (hit_x),
    .hit_y_i         (hit_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_column_o    (out_column),
    .out_row_o       (out_row),
    .in_wall_o       (in_wall),
    .out_texture_o   (out_texture),
    .tex_col_o       (tex_col),
    .tex_row_o       (tex_row)
  );

  wcm_pixel_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .column_i        (column),
    .row_i           (row),
    .wall_height_i   (wall_height),
    .texture_index_i (texture_index),
    .hit_vertical_i  (hit_vertical),
    .hit_x_i         (hit_x),
    .hit_y_i         (hit_y),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_column_i    (out_column),
    .out_row_i       (out_row),
    .in_wall_i       (in_wall),
    .out_texture_i   (out_texture),
    .tex_col_i       (tex_col),
    .tex_row_i       (tex_row),
    .errors_o        (mismatches),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("wall_column_texture_mapper_unit regression: fail");
    $finish;
  end

  // result side: after each accepted result, stall may be held high for a random hold, never while steady is set
  initial begin
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) hold = steady ? 0 : $urandom_range(0, 3);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one item: random gap first, then hold valid and payload until accepted
  task automatic send_pixel(input logic [9:0] col, input logic [8:0] r,
                            input logic [15:0] h, input logic [1:0] tex,
                            input logic vert, input logic [15:0] hx, input logic [15:0] hy);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    column        <= col;
    row           <= r;
    wall_height   <= h;
    texture_index <= tex;
    hit_vertical  <= vert;
    hit_x         <= hx;
    hit_y         <= hy;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // drop valid and hold off until every result is back
  task automatic wait_idle;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [15:0] h;
    logic [8:0]  r;
    logic [12:0] th;
    int          lo;
    int          hi;

    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_TEX_HEIGHT_0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    column        = '0;
    row           = '0;
    wall_height   = '0;
    texture_index = '0;
    hit_vertical  = 1'b0;
    hit_x         = '0;
    hit_y         = '0;
    steady        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset texture heights of 64
    send_pixel(10'd0,    9'd256, 16'd0,     2'd0, 1'b0, 16'd0,     16'd0);     // zero height
    send_pixel(10'd1,    9'd255, 16'd1,     2'd1, 1'b1, 16'd7,     16'd65);    // top edge, -1
    send_pixel(10'd2,    9'd256, 16'd1,     2'd2, 1'b0, 16'd63,    16'd0);     // end row
    send_pixel(10'd3,    9'd0,   16'd511,   2'd3, 1'b1, 16'd0,     16'd127);   // top edge row 0
    send_pixel(10'd4,    9'd510, 16'd511,   2'd0, 1'b0, 16'd1000,  16'd0);     // last wall row
    send_pixel(10'd5,    9'd511, 16'd511,   2'd1, 1'b0, 16'd64,    16'd0);     // just below span
    send_pixel(10'd6,    9'd0,   16'd512,   2'd2, 1'b1, 16'd0,     16'd4096);  // full screen
    send_pixel(10'd7,    9'd511, 16'd512,   2'd3, 1'b0, 16'd511,   16'd0);
    send_pixel(10'd1023, 9'd511, 16'd65535, 2'd3, 1'b1, 16'd0,     16'd65535); // tallest wall
    send_pixel(10'd512,  9'd0,   16'd65535, 2'd1, 1'b0, 16'd65535, 16'd0);
    send_pixel(10'd100,  9'd206, 16'd100,   2'd2, 1'b0, 16'd33,    16'd0);     // span start
    send_pixel(10'd101,  9'd305, 16'd100,   2'd0, 1'b1, 16'd0,     16'd12345); // span end - 1
    send_pixel(10'd102,  9'd205, 16'd100,   2'd1, 1'b0, 16'd9,     16'd0);     // above span
    send_pixel(10'd341,  9'd500, 16'd300,   2'd2, 1'b0, 16'hAAAA,  16'h5555);
    wait_idle;

    // texture height extremes, plus writes to unused indexes that must be ignored
    write_reg(REG_TEX_HEIGHT_0, 13'd0);
    write_reg(REG_TEX_HEIGHT_1, 13'd1);
    write_reg(REG_TEX_HEIGHT_2, 13'd4096);
    write_reg(REG_TEX_HEIGHT_3, 13'h1FFF);
    write_reg(3'(REG_TEX_HEIGHT_3 + 1), 13'd0);
    write_reg(3'(REG_TEX_HEIGHT_3 + 4), 13'h1FFF);
    send_pixel(10'd20,  9'd300, 16'd200,   2'd0, 1'b0, 16'd5,   16'd0);  // zero texture height
    send_pixel(10'd21,  9'd355, 16'd200,   2'd1, 1'b1, 16'd0,   16'd77);
    send_pixel(10'd22,  9'd256, 16'd2,     2'd2, 1'b0, 16'd88,  16'd0);
    send_pixel(10'd23,  9'd511, 16'd65535, 2'd3, 1'b0, 16'd99,  16'd0);  // saturates
    send_pixel(10'd24,  9'd511, 16'd512,   2'd3, 1'b1, 16'd0,   16'd3);
    send_pixel(10'd25,  9'd511, 16'd512,   2'd2, 1'b0, 16'd200, 16'd0);
    send_pixel(10'd26,  9'd511, 16'd1000,  2'd3, 1'b0, 16'd300, 16'd0);  // saturates

    // random phases, each with fresh texture heights written while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle;
      steady = (ph == 2);
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 5))
          0:       th = 13'd1;
          1:       th = 13'd4096;
          2:       th = 13'd0;
          3:       th = 13'h1FFF;
          4:       th = 13'($urandom);
          default: th = 13'($urandom_range(1, 4096));
        endcase
        write_reg(3'(REG_TEX_HEIGHT_0 + k), th);
      end
      write_reg(3'(REG_TEX_HEIGHT_3 + $urandom_range(1, 4)), 13'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly on-screen walls, some zero, tall or fully random heights
        case ($urandom_range(0, 9))
          0:       h = 16'd0;
          1:       h = 16'($urandom_range(SCREEN_HEIGHT, 65535));
          2:       h = 16'($urandom);
          default: h = 16'($urandom_range(1, SCREEN_HEIGHT - 1));
        endcase
        // aim most rows near the span so both edges get hit
        if (h != 0 && h < SCREEN_HEIGHT && $urandom_range(0, 3) != 0) begin
          lo = (SCREEN_HEIGHT - h) / 2;
          hi = (SCREEN_HEIGHT + h) / 2;
          lo = (lo > 0) ? lo - 1 : 0;
          hi = (hi > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : hi;
          r  = 9'($urandom_range(lo, hi));
        end else begin
          r = 9'($urandom_range(0, 511));
        end
        send_pixel(10'($urandom_range(0, 1023)), r, h, 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end
    end

    wait_idle;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("wall_column_texture_mapper_unit regression: pass");
    end else begin
      $display("wall_column_texture_mapper_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/wcm_pkg.sv
rtl/wcm_div_step.sv
rtl/wall_column_texture_mapper_unit.sv
bench/wcm_pixel_checker.sv
bench/tb_top.sv
